[rtl/core/dtoi_pkg.sv]
// Package for the decimal text to int32 parser.
// Holds the transaction payload types, parse phase and state types, and status codes.
// No dependencies.
package dtoi_pkg;

  // Input transaction: one UTF-16 code unit and the end-of-string mark.
  typedef struct packed {
    logic [15:0] character;
    logic        last;
  } in_t;

  // Output transaction: parsed value and status.
  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_t;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FORMAT   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_POS_SIGN = 1'b0;
  localparam logic CFG_NEG_SIGN = 1'b1;

  // Magnitude at which the next digit reaches the ten-digit limit.
  localparam logic [31:0] LIMIT_DIV = 32'd214748364;

  // Character codes.
  localparam logic [15:0] CH_NUL  = 16'h0000;
  localparam logic [15:0] CH_ZERO = 16'h0030;
  localparam logic [15:0] CH_NINE = 16'h0039;

  // Parse phases.
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_LEAD   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_LIMIT  = 3'd4,
    PH_DONE   = 3'd5
  } phase_t;

  // Running parse state carried from one character to the next.
  typedef struct packed {
    phase_t      phase;
    logic [31:0] magnitude;
    logic        negative;
    logic        got_digit;
    logic [1:0]  error_code;
  } parse_t;

  localparam parse_t PARSE_CLEAR = '{
    phase:       PH_START,
    magnitude:   32'd0,
    negative:    1'b0,
    got_digit:   1'b0,
    error_code:  ST_OK
  };

endpackage

[rtl/core/dtoi_step.sv]
// Combinational per-character step of the parser: next parse state and result.
// Depends on dtoi_pkg.
module dtoi_step (
  input  dtoi_pkg::parse_t cur,
  input  logic [15:0]      character,
  input  logic             last,
  input  logic [15:0]      positive_sign_char,
  input  logic [15:0]      negative_sign_char,
  output dtoi_pkg::parse_t nxt,
  output dtoi_pkg::out_t   result
);

  // Unicode whitespace set; NUL is not whitespace.
  function automatic logic is_space(input logic [15:0] c);
    logic sp;
    sp = 1'b0;
    if (c >= 16'h0009 && c <= 16'h000D) sp = 1'b1;
    if (c == 16'h0020 || c == 16'h0085 || c == 16'h00A0 || c == 16'h1680) sp = 1'b1;
    if (c >= 16'h2000 && c <= 16'h200A) sp = 1'b1;
    if (c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
        c == 16'h3000) sp = 1'b1;
    return sp;
  endfunction

  logic        space;
  logic        digit;
  logic [3:0]  d;
  logic [31:0] mag_x10;
  logic        may_sign;
  logic        consumed;
  dtoi_pkg::phase_t eff_phase;
  logic [31:0] mag_neg;

  assign space   = is_space(character);
  assign digit   = (character >= dtoi_pkg::CH_ZERO) && (character <= dtoi_pkg::CH_NINE);
  assign d       = character[3:0];
  assign mag_x10 = {cur.magnitude[28:0], 3'b000} + {cur.magnitude[30:0], 1'b0}
                 + {28'd0, d};

  // Next parse state.
  always_comb begin
    nxt       = cur;
    eff_phase = cur.phase;
    consumed  = 1'b0;
    may_sign  = 1'b0;

    // Leading whitespace and the optional sign.
    if (cur.phase == dtoi_pkg::PH_START || cur.phase == dtoi_pkg::PH_LEAD) begin
      if (space) begin
        nxt.phase = dtoi_pkg::PH_LEAD;
        consumed  = 1'b1;
      end else begin
        may_sign  = !(cur.phase == dtoi_pkg::PH_START && last);
        nxt.phase = dtoi_pkg::PH_DIGITS;
        eff_phase = dtoi_pkg::PH_DIGITS;
        if (may_sign && character == positive_sign_char) begin
          consumed = 1'b1;
        end else if (may_sign && character == negative_sign_char) begin
          nxt.negative = 1'b1;
          consumed     = 1'b1;
        end
      end
    end

    // Digits, trailing whitespace and errors.
    if (!consumed) begin
      unique case (eff_phase)
        dtoi_pkg::PH_DIGITS: begin
          if (character == dtoi_pkg::CH_NUL) begin
            nxt.phase = dtoi_pkg::PH_DONE;
          end else if (digit) begin
            if (cur.magnitude > dtoi_pkg::LIMIT_DIV) begin
              nxt.error_code = dtoi_pkg::ST_OVERFLOW;
              nxt.phase      = dtoi_pkg::PH_DONE;
            end else if (cur.magnitude == dtoi_pkg::LIMIT_DIV) begin
              if (d > 4'd7 && (!cur.negative || d > 4'd8)) begin
                nxt.error_code = dtoi_pkg::ST_OVERFLOW;
                nxt.phase      = dtoi_pkg::PH_DONE;
              end else begin
                nxt.magnitude = mag_x10;
                nxt.got_digit = 1'b1;
                nxt.phase     = dtoi_pkg::PH_LIMIT;
              end
            end else begin
              nxt.magnitude = mag_x10;
              nxt.got_digit = 1'b1;
            end
          end else if (space) begin
            nxt.phase = dtoi_pkg::PH_TRAIL;
          end else begin
            nxt.error_code = dtoi_pkg::ST_FORMAT;
            nxt.phase      = dtoi_pkg::PH_DONE;
          end
        end
        dtoi_pkg::PH_TRAIL: begin
          if (character != dtoi_pkg::CH_NUL && !space) begin
            nxt.error_code = dtoi_pkg::ST_FORMAT;
            nxt.phase      = dtoi_pkg::PH_DONE;
          end
        end
        dtoi_pkg::PH_LIMIT: begin
          if (character != dtoi_pkg::CH_NUL && !space) begin
            nxt.error_code = dtoi_pkg::ST_OVERFLOW;
            nxt.phase      = dtoi_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result as it would be reported if this character ends the string.
  assign mag_neg = 32'd0 - nxt.magnitude;

  always_comb begin
    result.value  = 32'sd0;
    result.status = dtoi_pkg::ST_OK;
    if (nxt.phase == dtoi_pkg::PH_START || nxt.phase == dtoi_pkg::PH_LEAD) begin
      result.status = dtoi_pkg::ST_FORMAT;
    end else if (nxt.error_code != dtoi_pkg::ST_OK) begin
      result.status = nxt.error_code;
    end else if (!nxt.got_digit) begin
      result.status = dtoi_pkg::ST_FORMAT;
    end else begin
      result.value = nxt.negative ? $signed(mag_neg) : $signed(nxt.magnitude);
    end
  end

endmodule

[rtl/core/decimal_text_to_int32_parser.sv]
// Top level of the decimal text to int32 parser: input register, parse state, result register.
// Depends on dtoi_pkg and dtoi_step.
//
// The parser takes one character per clock cycle, sustained, and presents a result once the
// transaction that carries the last character is accepted: the character is held in the input
// register, and the step logic loads the result register from it. The rate is set by the
// parse-state update loop (multiply-by-ten accumulate with the limit compare). Input stalls
// only when a last character waits in the input register while an earlier result is still
// held by a stalled output.
module decimal_text_to_int32_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  dtoi_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output dtoi_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data
);

  logic             in_valid_r;
  dtoi_pkg::in_t    in_r;
  dtoi_pkg::parse_t state;
  dtoi_pkg::parse_t state_next;
  dtoi_pkg::out_t   result;
  logic [15:0]      positive_sign_char;
  logic [15:0]      negative_sign_char;
  logic             out_free;
  logic             proc;
  logic             in_take;

  // Handshake control.
  assign out_free = !out_valid || !out_stall;
  assign proc     = in_valid_r && (!in_r.last || out_free);
  assign in_stall = in_valid_r && !proc;
  assign in_take  = in_valid && !in_stall;

  // Per-character parse step.
  dtoi_step u_step (
    .cur                (state),
    .character          (in_r.character),
    .last               (in_r.last),
    .positive_sign_char (positive_sign_char),
    .negative_sign_char (negative_sign_char),
    .nxt                (state_next),
    .result             (result)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      positive_sign_char <= 16'd43;
      negative_sign_char <= 16'd45;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtoi_pkg::CFG_POS_SIGN: positive_sign_char <= cfg_data;
        dtoi_pkg::CFG_NEG_SIGN: negative_sign_char <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_r <= 1'b0;
    end else if (!in_valid_r || proc) begin
      in_valid_r <= in_valid;
    end
    if (in_take) begin
      in_r <= in_data;
    end
  end

  // Parse state; cleared after every string.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtoi_pkg::PARSE_CLEAR;
    end else if (proc) begin
      state <= in_r.last ? dtoi_pkg::PARSE_CLEAR : state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && in_r.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (proc && in_r.last) begin
      out_data <= result;
    end
  end

  // A failed parse always reports zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != dtoi_pkg::ST_OK |-> out_data.value == 32'sd0)
    else $error("nonzero value with error status");

  // Only defined status codes are reported.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == dtoi_pkg::ST_OK ||
                   out_data.status == dtoi_pkg::ST_FORMAT ||
                   out_data.status == dtoi_pkg::ST_OVERFLOW))
    else $error("undefined status code");

  // The end of a string leaves a clean parse state behind.
  assert property (@(posedge clk) disable iff (rst)
    proc && in_r.last |=> state.phase == dtoi_pkg::PH_START &&
                          state.magnitude == 32'd0 && !state.negative &&
                          !state.got_digit)
    else $error("parse state not cleared after a string");

  // Input is held back only for a last character behind a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_valid_r && in_r.last && out_valid && out_stall)
    else $error("input stalled without cause");

endmodule
